@@ design/ookpwd_pkg.sv @@
// Shared types and constants of the OOK pulse-width decoder.
package ookpwd_pkg;

  localparam int unsigned WIDTH_W     = 15;
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned STORE_AW    = 3;
  localparam int unsigned TOTAL_W     = 4;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned DIV_STEPS   = 16;
  localparam int unsigned DIV_CNT_W   = 5;

  localparam logic [1:0] KIND_BIT     = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_BYTE    = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  localparam logic REG_SPARSE_MODE = 1'b0;

  typedef struct packed {
    logic [1:0]         kind;
    logic               bit_value;
    logic [BYTE_W-1:0]  byte_value;
    logic [COUNT_W-1:0] pair_count;
    logic [SUM_W-1:0]   average_width;
    logic               final_res;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ design/ookpwd_if.sv @@
// Channel interfaces: pulse input and decoded result output.
interface ookpwd_pulse_if;
  logic        valid;
  logic        ready;
  logic [14:0] pulse_width;
  logic        train_end;

  modport source (output valid, output pulse_width, output train_end, input ready);
  modport sink (input valid, input pulse_width, input train_end, output ready);
endinterface

interface ookpwd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        bit_value;
  logic [7:0]  byte_value;
  logic [6:0]  pair_count;
  logic [15:0] average_width;
  logic        final_res;

  modport source (output valid, output kind, output bit_value, output byte_value,
                  output pair_count, output average_width, output final_res,
                  input ready);
  modport sink (input valid, input kind, input bit_value, input byte_value,
                input pair_count, input average_width, input final_res,
                output ready);
endinterface

@@ design/ook_pulse_width_decoder.sv @@
// Top level of the OOK pulse-width decoder: train sequencer and config port.
//
// Pulse widths enter on pulse_i, one transaction per pulse, train_end set on
// the last pulse of a train. The first pulse of a train is the sync pulse;
// each later pair of widths gives one bit. Results leave on result_o from an
// output register. A write to sparse_mode (byte address 0) over the APB port
// is taken at the access cycle; pready is always high.
// A bit result passes from the S_BIT state into the output register before it
// is valid on result_o. A pulse without a result leaves the sequencer idle,
// so the input stays free for the next pulse.
// End of train in dense mode: the average comes from a restoring divider
// (S_DIV_GO, S_DIV_WAIT) and is loaded in S_SUM; each stored byte then takes
// one store read and one output load, and the end marker a final store check
// and the load. In sparse mode the readout skips the divider and the summary.
// pulse_i.ready is high only while the sequencer is idle.
// A stalled receiver holds the current result in the output register and
// halts the sequencer; nothing is dropped.
// Reset clears the train state, the sparse_mode register and the output
// register; the byte store needs no clearing.
module ook_pulse_width_decoder #(
  parameter int unsigned MAX_PULSES = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ookpwd_pulse_if.sink                   pulse_i,
  ookpwd_result_if.source                result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ookpwd_pkg::PADDR_W-1:0] paddr,
  input  logic [ookpwd_pkg::PDATA_W-1:0] pwdata,
  output logic [ookpwd_pkg::PDATA_W-1:0] prdata,
  output logic                           pready
);
  import ookpwd_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_PULSES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_BIT, S_DIV_GO, S_DIV_WAIT, S_SUM, S_RD, S_BYTE, S_END
  } state_e;

  state_e               state_q;
  logic                 sparse_q;
  logic [POS_W-1:0]     pos_q;
  logic [WIDTH_W-1:0]   held_q;
  logic [SUM_W-1:0]     sum_q;
  logic [COUNT_W-1:0]   pairs_q;
  logic [2:0]           bits_q;
  logic [BYTE_W-1:0]    shift_q;
  logic [TOTAL_W-1:0]   total_q;
  logic [TOTAL_W-1:0]   rd_idx_q;
  logic                 bit_q;
  logic                 last_q;
  logic                 out_valid_q;
  result_t              out_q;

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic                 pos_ok;
  logic                 is_pair;
  logic                 is_first;
  logic                 bit_d;
  logic [WIDTH_W-1:0]   short_w;
  logic [SUM_W-1:0]     sum_d;
  logic [BYTE_W-1:0]    shift_d;
  logic                 ram_we;
  logic                 ram_re;
  logic [BYTE_W-1:0]    ram_rdata;
  logic                 div_start;
  div_stat_t            div_stat;
  logic [SUM_W-1:0]     quotient;
  logic [SUM_W-1:0]     avg;
  logic                 cfg_we;

  assign accept   = pulse_i.valid && pulse_i.ready;
  assign out_free = !out_valid_q || result_o.ready;
  assign out_load = out_free && (state_q inside {S_BIT, S_SUM, S_BYTE, S_END});

  assign pos_ok   = pos_q < POS_W'(MAX_PULSES);
  assign is_pair  = pos_ok && (pos_q != '0) && !pos_q[0];
  assign is_first = pos_ok && pos_q[0];
  assign bit_d    = !(held_q < pulse_i.pulse_width);
  assign short_w  = bit_d ? pulse_i.pulse_width : held_q;
  assign sum_d    = sum_q + SUM_W'(short_w);
  assign shift_d  = {shift_q[BYTE_W-2:0], bit_d};

  assign ram_we    = accept && is_pair && (bits_q == 3'd7) && !total_q[TOTAL_W-1];
  assign ram_re    = (state_q == S_RD) && (rd_idx_q < total_q);
  assign div_start = (state_q == S_DIV_GO);
  assign avg       = (pairs_q == '0) ? '0 : {quotient[SUM_W-3:0], 2'b00};

  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SPARSE_MODE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPARSE_MODE) ? PDATA_W'(sparse_q) : '0;

  ookpwd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (total_q[STORE_AW-1:0]),
    .wdata_i (shift_d),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[STORE_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  ookpwd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (pairs_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sparse_q    <= 1'b0;
      pos_q       <= '0;
      held_q      <= '0;
      sum_q       <= '0;
      pairs_q     <= '0;
      bits_q      <= '0;
      shift_q     <= '0;
      total_q     <= '0;
      rd_idx_q    <= '0;
      bit_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we) begin
        sparse_q <= pwdata[0];
      end
      out_valid_q <= out_load || (out_valid_q && !result_o.ready);
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            last_q <= pulse_i.train_end;
            bit_q  <= bit_d;
            if (pos_ok) begin
              pos_q <= pos_q + POS_W'(1);
            end
            if (is_first) begin
              held_q <= pulse_i.pulse_width;
            end
            if (is_pair) begin
              sum_q   <= sum_d;
              pairs_q <= pairs_q + COUNT_W'(1);
              bits_q  <= bits_q + 3'd1;
              shift_q <= (bits_q == 3'd7) ? '0 : shift_d;
              if (ram_we) begin
                total_q <= total_q + TOTAL_W'(1);
              end
            end
            if (is_pair && !sparse_q) begin
              state_q <= S_BIT;
            end else if (pulse_i.train_end) begin
              state_q <= sparse_q ? S_RD : S_DIV_GO;
            end
          end
        end
        S_BIT: begin
          if (out_free) begin
            out_q <= {KIND_BIT, bit_q, BYTE_W'(0), COUNT_W'(0), SUM_W'(0), 1'b0};
            if (!last_q) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= sparse_q ? S_RD : S_DIV_GO;
            end
          end
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_q   <= {KIND_SUMMARY, 1'b0, BYTE_W'(0), pairs_q, avg, 1'b0};
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= ram_re ? S_BYTE : S_END;
        end
        S_BYTE: begin
          if (out_free) begin
            out_q    <= {KIND_BYTE, 1'b0, ram_rdata, COUNT_W'(0), SUM_W'(0), 1'b0};
            rd_idx_q <= rd_idx_q + TOTAL_W'(1);
            state_q  <= S_RD;
          end
        end
        S_END: begin
          if (out_free) begin
            out_q    <= {KIND_END, 1'b0, BYTE_W'(0), COUNT_W'(0), SUM_W'(0), 1'b1};
            pos_q    <= '0;
            held_q   <= '0;
            sum_q    <= '0;
            pairs_q  <= '0;
            bits_q   <= '0;
            shift_q  <= '0;
            total_q  <= '0;
            rd_idx_q <= '0;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign pulse_i.ready          = (state_q == S_IDLE);
  assign result_o.valid         = out_valid_q;
  assign result_o.kind          = out_q.kind;
  assign result_o.bit_value     = out_q.bit_value;
  assign result_o.byte_value    = out_q.byte_value;
  assign result_o.pair_count    = out_q.pair_count;
  assign result_o.average_width = out_q.average_width;
  assign result_o.final_res     = out_q.final_res;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOTAL_W'(STORE_DEPTH))
    else $error("byte count exceeds store depth");

  a_final_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.final_res |-> result_o.kind == KIND_END)
    else $error("final flag on a result that is not the end marker");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV_WAIT)
    else $error("divider finished outside the wait state");

  a_end_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && pulse_i.train_end |=> state_q != S_IDLE)
    else $error("end of train did not start the readout");

  a_rd_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_idx_q <= total_q)
    else $error("readout index passed the byte count");
`endif

endmodule

@@ design/ookpwd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ookpwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ookpwd_div.sv @@
// Restoring divider, one quotient bit per cycle, for the average pulse width.
module ookpwd_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ookpwd_pkg::SUM_W-1:0]   dividend_i,
  input  logic [ookpwd_pkg::COUNT_W-1:0] divisor_i,
  output ookpwd_pkg::div_stat_t          stat_o,
  output logic [ookpwd_pkg::SUM_W-1:0]   quotient_o
);
  import ookpwd_pkg::*;

  logic [SUM_W-1:0]     quo_q;
  logic [COUNT_W-1:0]   rem_q;
  logic [COUNT_W-1:0]   dsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [COUNT_W:0]     trial;
  logic                 ge;
  logic [COUNT_W:0]     diff;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], ge};
      rem_q <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule
